// ===== hdl/gmsc_pkg.sv =====
// shared constants, types and address wrap functions for the one-star cost engine
package gmsc_pkg;

  localparam int VERTEX_DEPTH   = 1024;
  localparam int TERMINAL_DEPTH = 1024;
  localparam int GROUP_MAX      = 16;

  localparam int RESULT_LIMIT = 16;
  localparam int GROUP_LIMIT  = (GROUP_MAX < RESULT_LIMIT) ? GROUP_MAX : RESULT_LIMIT;

  localparam int TA_W  = (TERMINAL_DEPTH > 1) ? $clog2(TERMINAL_DEPTH) : 1;
  localparam int VA_W  = $clog2(VERTEX_DEPTH);
  localparam int GRP_W = (GROUP_LIMIT > 1) ? $clog2(GROUP_LIMIT) : 1;

  localparam int OP_W   = 2;
  localparam int ID_W   = 10;
  localparam int DIST_W = 31;
  localparam int CNT_W  = 5;
  localparam int SIZE_W = 7;
  localparam int IDX_W  = 4;

  localparam logic [DIST_W-1:0] NO_COST = '1;

  localparam int RECIP_SH = 20;
  localparam int T_RECIP  = ((1 << RECIP_SH) + TERMINAL_DEPTH - 1) / TERMINAL_DEPTH;
  localparam int V_RECIP  = ((1 << RECIP_SH) + VERTEX_DEPTH - 1) / VERTEX_DEPTH;

  typedef enum logic [OP_W-1:0] {
    OP_TERM = 2'd0,
    OP_DIST = 2'd1,
    OP_ROOT = 2'd2
  } op_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_TREAD,
    ST_TCHK,
    ST_DCHK,
    ST_SKIP,
    ST_EMIT
  } state_e;

  typedef struct packed {
    logic start;
    logic wr_term;
    logic wr_dist;
    logic hit;
    logic take_min;
    logic adv;
    logic next_group;
  } cmd_t;

  typedef struct packed {
    logic none;
    logic size_zero;
    logic is_root;
    logic member_last;
    logic group_last;
  } stat_t;

  // remainder by reciprocal multiply, exact for 10-bit operands
  function automatic logic [TA_W-1:0] term_wrap(input logic [ID_W-1:0] x);
    logic [31:0] q;
    logic [31:0] r;
    q = (32'(x) * 32'(T_RECIP)) >> RECIP_SH;
    r = 32'(x) - q * 32'(TERMINAL_DEPTH);
    return TA_W'(r);
  endfunction

  function automatic logic [VA_W-1:0] vert_wrap(input logic [ID_W-1:0] x);
    logic [31:0] q;
    logic [31:0] r;
    q = (32'(x) * 32'(V_RECIP)) >> RECIP_SH;
    r = 32'(x) - q * 32'(VERTEX_DEPTH);
    return VA_W'(r);
  endfunction

endpackage

// ===== hdl/gmsc_ram.sv =====
// generic single write port ram with registered read
module gmsc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                     clk_i,
  input  logic                                     we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                         wdata_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

// ===== hdl/gmsc_dp.sv =====
// datapath: terminal table, distance row, walk counters and running minimum
module gmsc_dp
  import gmsc_pkg::*;
(
  input  logic              clk_i,
  input  cmd_t              cmd_i,
  input  logic [ID_W-1:0]   slot_i,
  input  logic [ID_W-1:0]   vertex_id_i,
  input  logic [DIST_W-1:0] distance_i,
  input  logic [CNT_W-1:0]  group_count_i,
  input  logic [SIZE_W-1:0] group_size_i,
  output stat_t             stat_o,
  output logic [IDX_W-1:0]  group_index_o,
  output logic [DIST_W-1:0] cost_o
);

  logic [ID_W-1:0]   root_q, root_d;
  logic [GRP_W-1:0]  grp_q, grp_d;
  logic [GRP_W-1:0]  last_grp_q, last_grp_d;
  logic [SIZE_W-1:0] mbr_q, mbr_d;
  logic [TA_W-1:0]   addr_q, addr_d;
  logic [DIST_W-1:0] best_q, best_d;

  logic [ID_W-1:0]   term_rd;
  logic [DIST_W-1:0] dist_rd;
  logic [CNT_W-1:0]  cnt_clamp;

  gmsc_ram #(.WIDTH(ID_W), .DEPTH(TERMINAL_DEPTH)) u_term_ram (
    .clk_i  (clk_i),
    .we_i   (cmd_i.wr_term),
    .waddr_i(term_wrap(slot_i)),
    .wdata_i(vertex_id_i),
    .raddr_i(addr_q),
    .rdata_o(term_rd)
  );

  gmsc_ram #(.WIDTH(DIST_W), .DEPTH(VERTEX_DEPTH)) u_dist_ram (
    .clk_i  (clk_i),
    .we_i   (cmd_i.wr_dist),
    .waddr_i(vert_wrap(vertex_id_i)),
    .wdata_i(distance_i),
    .raddr_i(vert_wrap(term_rd)),
    .rdata_o(dist_rd)
  );

  assign cnt_clamp = (group_count_i > CNT_W'(GROUP_LIMIT)) ? CNT_W'(GROUP_LIMIT)
                                                          : group_count_i;

  always_comb begin
    root_d     = root_q;
    grp_d      = grp_q;
    last_grp_d = last_grp_q;
    mbr_d      = mbr_q;
    addr_d     = addr_q;
    best_d     = best_q;
    if (cmd_i.start) begin
      root_d     = vertex_id_i;
      grp_d      = '0;
      last_grp_d = GRP_W'(cnt_clamp - CNT_W'(1));
      mbr_d      = '0;
      addr_d     = '0;
      best_d     = NO_COST;
    end
    if (cmd_i.take_min && (dist_rd < best_q)) begin
      best_d = dist_rd;
    end
    if (cmd_i.hit) begin
      best_d = '0;
    end
    if (cmd_i.adv) begin
      mbr_d  = mbr_q + SIZE_W'(1);
      addr_d = (addr_q == TA_W'(TERMINAL_DEPTH - 1)) ? '0 : addr_q + TA_W'(1);
    end
    if (cmd_i.next_group) begin
      grp_d  = grp_q + GRP_W'(1);
      mbr_d  = '0;
      best_d = NO_COST;
    end
  end

  always_ff @(posedge clk_i) begin
    root_q     <= root_d;
    grp_q      <= grp_d;
    last_grp_q <= last_grp_d;
    mbr_q      <= mbr_d;
    addr_q     <= addr_d;
    best_q     <= best_d;
  end

  assign stat_o.none        = (group_count_i == '0);
  assign stat_o.size_zero   = (group_size_i == '0);
  assign stat_o.is_root     = (term_rd == root_q);
  assign stat_o.member_last = (mbr_q == group_size_i - SIZE_W'(1));
  assign stat_o.group_last  = (grp_q == last_grp_q);

  assign group_index_o = IDX_W'(grp_q);
  assign cost_o        = best_q;

endmodule

// ===== hdl/gmsc_ctrl.sv =====
// controller state machine sequencing loads and the group walk
module gmsc_ctrl
  import gmsc_pkg::*;
(
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  input  logic [OP_W-1:0] op_i,
  input  logic            out_ready_i,
  input  stat_t           stat_i,
  output logic            in_ready_o,
  output logic            out_valid_o,
  output cmd_t            cmd_o
);

  state_e state_q, state_d;
  logic   in_acc;

  assign in_acc = in_valid_i && in_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_acc && (op_i == OP_ROOT) && !stat_i.none) begin
          state_d = stat_i.size_zero ? ST_EMIT : ST_TREAD;
        end
      end
      ST_TREAD: state_d = ST_TCHK;
      ST_TCHK: begin
        if (stat_i.is_root) begin
          state_d = stat_i.member_last ? ST_EMIT : ST_SKIP;
        end else begin
          state_d = ST_DCHK;
        end
      end
      ST_DCHK: state_d = stat_i.member_last ? ST_EMIT : ST_TREAD;
      ST_SKIP: state_d = stat_i.member_last ? ST_EMIT : ST_SKIP;
      ST_EMIT: begin
        if (out_ready_i) begin
          if (stat_i.group_last) begin
            state_d = ST_IDLE;
          end else begin
            state_d = stat_i.size_zero ? ST_EMIT : ST_TREAD;
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o       = '0;
    in_ready_o  = 1'b0;
    out_valid_o = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o     = 1'b1;
        cmd_o.wr_term  = in_valid_i && (op_i == OP_TERM);
        cmd_o.wr_dist  = in_valid_i && (op_i == OP_DIST);
        cmd_o.start    = in_valid_i && (op_i == OP_ROOT);
      end
      ST_TCHK: begin
        cmd_o.hit = stat_i.is_root;
        cmd_o.adv = stat_i.is_root;
      end
      ST_DCHK: begin
        cmd_o.take_min = 1'b1;
        cmd_o.adv      = 1'b1;
      end
      ST_SKIP: cmd_o.adv = 1'b1;
      ST_EMIT: begin
        out_valid_o      = 1'b1;
        cmd_o.next_group = out_ready_i;
      end
      default: cmd_o = '0;
    endcase
  end

endmodule

// ===== hdl/group_min_star_cost.sv =====
// top level of the group one-star cost engine with stream and register ports
// Load items (terminal slot or distance entry writes) are written as they are accepted.
// A compute item produces one result per group, for at most GROUP_LIMIT groups; for
// each member of a group the terminal table and then the distance row are read in
// series (states TREAD, TCHK, DCHK) until the root is found among the members, after
// which each remaining member is passed over in SKIP; each result is then held on the
// output in EMIT until it is taken, and no new item is accepted until the last is taken.
module group_min_star_cost
  import gmsc_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [55:0] s_axis_tdata,  // slot, vertex_id, distance
  input  logic [1:0]  s_axis_tuser,  // opcode
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [39:0] m_axis_tdata,  // group_index, cost
  output logic        m_axis_tlast,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam logic REG_COUNT = 1'b0;
  localparam logic REG_SIZE  = 1'b1;

  logic [CNT_W-1:0]  group_count_q, group_count_d;
  logic [SIZE_W-1:0] group_size_q, group_size_d;
  logic              cfg_wr;

  cmd_t              cmd;
  stat_t             stat;
  logic [IDX_W-1:0]  group_index;
  logic [DIST_W-1:0] cost;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_comb begin
    group_count_d = group_count_q;
    group_size_d  = group_size_q;
    if (cfg_wr) begin
      case (paddr[2])
        REG_COUNT: group_count_d = pwdata[CNT_W-1:0];
        REG_SIZE:  group_size_d  = pwdata[SIZE_W-1:0];
        default:   group_count_d = group_count_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      group_count_q <= CNT_W'(1);
      group_size_q  <= SIZE_W'(1);
    end else begin
      group_count_q <= group_count_d;
      group_size_q  <= group_size_d;
    end
  end

  always_comb begin
    case (paddr[2])
      REG_COUNT: prdata = 32'(group_count_q);
      REG_SIZE:  prdata = 32'(group_size_q);
      default:   prdata = '0;
    endcase
  end

  gmsc_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .op_i       (s_axis_tuser),
    .out_ready_i(m_axis_tready),
    .stat_i     (stat),
    .in_ready_o (s_axis_tready),
    .out_valid_o(m_axis_tvalid),
    .cmd_o      (cmd)
  );

  gmsc_dp u_dp (
    .clk_i        (clk_i),
    .cmd_i        (cmd),
    .slot_i       (s_axis_tdata[9:0]),
    .vertex_id_i  (s_axis_tdata[19:10]),
    .distance_i   (s_axis_tdata[50:20]),
    .group_count_i(group_count_q),
    .group_size_i (group_size_q),
    .stat_o       (stat),
    .group_index_o(group_index),
    .cost_o       (cost)
  );

  assign m_axis_tdata = {5'b0, cost, group_index};
  assign m_axis_tlast = stat.group_last;

  a_one_item_at_a_time: assert property (
    @(posedge clk_i) disable iff (!rst_ni) m_axis_tvalid |-> !s_axis_tready
  ) else $error("input taken while a result is pending");

  a_last_ends_run: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tready && m_axis_tlast) |=> s_axis_tready
  ) else $error("block busy after final result");

  a_no_groups_no_work: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready && (s_axis_tuser == OP_ROOT) && (group_count_q == '0))
    |=> (s_axis_tready && !m_axis_tvalid)
  ) else $error("compute with zero groups left the idle state");

  a_load_stays_idle: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready && (s_axis_tuser != OP_ROOT)) |=> s_axis_tready
  ) else $error("load item started a walk");

endmodule
